// File: rtl/cvg_pkg.sv
package cvg_pkg;

	localparam int RADIUS_W = 16;
	localparam int COUNT_W  = 13;
	localparam int IDX_W    = 12;
	localparam int PHASE_W  = 16;
	localparam int STAGES   = 16;
	localparam int DIV_W    = IDX_W + PHASE_W;
	localparam int REM_W    = COUNT_W;
	localparam int VEC_W    = 32;
	localparam int COORD_W  = RADIUS_W + 1;
	localparam int SHIFT_W  = 5;
	localparam int PROD_W   = RADIUS_W + 1 + VEC_W;
	localparam int FRAC     = 30;
	localparam int SUM_W    = PROD_W - FRAC + 1;

	localparam logic [VEC_W-1:0] GAIN_Q30 = 32'd652032874;
	localparam logic [VEC_W-1:0] QUARTER  = 32'h4000_0000;
	localparam logic [VEC_W-1:0] HALF     = 32'h8000_0000;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd30;

	typedef enum logic {
		REG_RADIUS = 1'b0,
		REG_POINT_COUNT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic               valid;
		logic [REM_W-1:0]   rem;
		logic [DIV_W-1:0]   num;
		logic [PHASE_W-1:0] quo;
	} div_stage_t;

	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [VEC_W-1:0] x;
		logic [VEC_W-1:0] y;
		logic [VEC_W-1:0] z;
	} cordic_stage_t;

	// arctangent of 2^-i in 2^32 units per turn
	function automatic logic [VEC_W-1:0] atan_turn(input logic [SHIFT_W-1:0] i);
		logic [VEC_W-1:0] v;
		case (i)
			5'd0:  v = 32'h2000_0000;
			5'd1:  v = 32'h12E4_051E;
			5'd2:  v = 32'h09FB_385B;
			5'd3:  v = 32'h0511_11D4;
			5'd4:  v = 32'h028B_0D43;
			5'd5:  v = 32'h0145_D7E1;
			5'd6:  v = 32'h00A2_F61E;
			5'd7:  v = 32'h0051_7C55;
			5'd8:  v = 32'h0028_BE53;
			5'd9:  v = 32'h0014_5F2F;
			5'd10: v = 32'h000A_2F98;
			5'd11: v = 32'h0005_17CC;
			5'd12: v = 32'h0002_8BE6;
			5'd13: v = 32'h0001_45F3;
			5'd14: v = 32'h0000_A2FA;
			5'd15: v = 32'h0000_517D;
			5'd16: v = 32'h0000_28BE;
			5'd17: v = 32'h0000_145F;
			5'd18: v = 32'h0000_0A30;
			5'd19: v = 32'h0000_0518;
			5'd20: v = 32'h0000_028C;
			5'd21: v = 32'h0000_0146;
			5'd22: v = 32'h0000_00A3;
			5'd23: v = 32'h0000_0051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/cvg_div_cell.sv
module cvg_div_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [cvg_pkg::REM_W-1:0] den,
	input  cvg_pkg::div_stage_t       d,
	output cvg_pkg::div_stage_t       q
);
	import cvg_pkg::*;

	logic [REM_W:0]   trial;
	logic             ge;
	div_stage_t       nxt;

	// one restoring step: bring down the top dividend bit
	always_comb begin
		trial = {d.rem, d.num[DIV_W-1]};
		ge = trial >= {1'b0, den};
		nxt.valid = d.valid;
		nxt.rem = ge ? REM_W'(trial - {1'b0, den}) : trial[REM_W-1:0];
		nxt.num = {d.num[DIV_W-2:0], 1'b0};
		nxt.quo = {d.quo[PHASE_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (adv) begin
			q <= nxt;
		end
	end

endmodule

// File: rtl/cvg_cordic_cell.sv
module cvg_cordic_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [cvg_pkg::SHIFT_W-1:0] sh,
	input  cvg_pkg::cordic_stage_t      d,
	output cvg_pkg::cordic_stage_t      q
);
	import cvg_pkg::*;

	logic [VEC_W-1:0] xs;
	logic [VEC_W-1:0] ys;
	logic [VEC_W-1:0] at;
	logic             up;
	cordic_stage_t    nxt;

	always_comb begin
		xs = VEC_W'($signed(d.x) >>> sh);
		ys = VEC_W'($signed(d.y) >>> sh);
		at = atan_turn(sh);
		up = !d.z[VEC_W-1];
		nxt.valid = d.valid;
		nxt.neg = d.neg;
		nxt.x = up ? d.x - ys : d.x + ys;
		nxt.y = up ? d.y + xs : d.y - xs;
		nxt.z = up ? d.z - at : d.z + at;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (adv) begin
			q <= nxt;
		end
	end

endmodule

// File: rtl/circle_vertex_generator_unit.sv
// circle vertex generator
// input channel: vertex_index with vertex_valid / vertex_stall; a beat is taken
// on a rising edge with vertex_valid high and vertex_stall low
// output channel: x_coord, y_coord with coord_valid / coord_stall, one beat per
// input beat, in order
// configuration: cfg_we writes cfg_data into radius (index 0) or point_count
// (index 1); write only while no beat is in flight
// latency: 46 cycles from input beat to output beat (28 divider cells, 16
// cordic cells, one multiply stage, one round and clamp stage)
// throughput: one beat per cycle; the chain of cells is fully pipelined
// the phase is the quotient of a one-bit-per-cell restoring divider, which is
// what sets the latency, not the rate
// stall: when the output holds a beat and coord_stall is high the whole chain
// freezes and vertex_stall rises; nothing is lost or repeated
// reset: radius 0, point_count 30, all pipeline valid bits cleared
module circle_vertex_generator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         vertex_valid,
	output logic                         vertex_stall,
	input  logic [cvg_pkg::IDX_W-1:0]    vertex_index,
	output logic                         coord_valid,
	input  logic                         coord_stall,
	output logic [cvg_pkg::COORD_W-1:0]  x_coord,
	output logic [cvg_pkg::COORD_W-1:0]  y_coord,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [cvg_pkg::RADIUS_W-1:0] cfg_data
);
	import cvg_pkg::*;

	logic [RADIUS_W-1:0] radius_q;
	logic [COUNT_W-1:0]  point_count_q;
	logic [COUNT_W-1:0]  den;
	logic                adv;

	div_stage_t    div_chain [DIV_W+1];
	cordic_stage_t cor_chain [STAGES+1];

	logic [VEC_W-1:0] ang;
	logic signed [PROD_W-1:0] prod_sin_s1, prod_cos_s1;
	logic signed [PROD_W-1:0] prod_sin, prod_cos;
	logic                     valid_s1;
	logic [VEC_W-1:0]         sin_v, cos_v;
	logic signed [SUM_W-1:0]  rs, rc, rad_s, sum_x, sum_y, hi_s;
	logic [COORD_W-1:0]       x_nxt, y_nxt;
	logic                     out_valid_q;
	logic [COORD_W-1:0]       x_q, y_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
			point_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_RADIUS:      radius_q <= cfg_data;
				REG_POINT_COUNT: point_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero count behaves as one
	assign den = (point_count_q == '0) ? COUNT_W'(1) : point_count_q;

	// whole chain moves unless a finished beat is held back
	assign adv = !(out_valid_q && coord_stall);
	assign vertex_stall = !adv;

	// dividend is index * 2^16 plus half the count, for rounding half up;
	// the quotient taken mod 2^16 also absorbs the index reduction
	always_comb begin
		div_chain[0].valid = vertex_valid;
		div_chain[0].rem = '0;
		div_chain[0].num = {vertex_index, PHASE_W'(den >> 1)};
		div_chain[0].quo = '0;
	end

	for (genvar i = 0; i < DIV_W; i++) begin : g_div
		cvg_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.den    (den),
			.d      (div_chain[i]),
			.q      (div_chain[i+1])
		);
	end

	// fold the angle into the right half plane, flipping both outputs
	always_comb begin
		ang = {div_chain[DIV_W].quo, {(VEC_W-PHASE_W){1'b0}}};
		cor_chain[0].valid = div_chain[DIV_W].valid;
		cor_chain[0].x = GAIN_Q30;
		cor_chain[0].y = '0;
		if ($signed(ang) > $signed(QUARTER)) begin
			cor_chain[0].z = ang - HALF;
			cor_chain[0].neg = 1'b1;
		end else if ($signed(ang) < -$signed(QUARTER)) begin
			cor_chain[0].z = ang + HALF;
			cor_chain[0].neg = 1'b1;
		end else begin
			cor_chain[0].z = ang;
			cor_chain[0].neg = 1'b0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cor
		cvg_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.sh     (SHIFT_W'(i)),
			.d      (cor_chain[i]),
			.q      (cor_chain[i+1])
		);
	end

	// scale by radius
	always_comb begin
		sin_v = cor_chain[STAGES].neg ? -cor_chain[STAGES].y : cor_chain[STAGES].y;
		cos_v = cor_chain[STAGES].neg ? -cor_chain[STAGES].x : cor_chain[STAGES].x;
		prod_sin = $signed({1'b0, radius_q}) * $signed(sin_v);
		prod_cos = $signed({1'b0, radius_q}) * $signed(cos_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			prod_sin_s1 <= '0;
			prod_cos_s1 <= '0;
		end else if (adv) begin
			valid_s1 <= cor_chain[STAGES].valid;
			prod_sin_s1 <= prod_sin;
			prod_cos_s1 <= prod_cos;
		end
	end

	// round half up at the q30 point, offset by the centre, clamp to 0..2r
	always_comb begin
		rs = SUM_W'((prod_sin_s1 + (PROD_W'(1) <<< (FRAC - 1))) >>> FRAC);
		rc = SUM_W'((prod_cos_s1 + (PROD_W'(1) <<< (FRAC - 1))) >>> FRAC);
		rad_s = SUM_W'({1'b0, radius_q});
		hi_s = SUM_W'({radius_q, 1'b0});
		sum_x = rad_s + rs;
		sum_y = rad_s - rc;
		if (sum_x < 0) x_nxt = '0;
		else if (sum_x > hi_s) x_nxt = COORD_W'(hi_s);
		else x_nxt = COORD_W'(sum_x);
		if (sum_y < 0) y_nxt = '0;
		else if (sum_y > hi_s) y_nxt = COORD_W'(hi_s);
		else y_nxt = COORD_W'(sum_y);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			x_q <= x_nxt;
			y_q <= y_nxt;
		end
	end

	assign coord_valid = out_valid_q;
	assign x_coord = x_q;
	assign y_coord = y_q;

endmodule
